@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// When the antecedent holds, the consequent must hold at the next clock edge.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/fcst_pkg.sv @@
// ----------------------------------------------------------------------------
// fcst_pkg
// Types, constants and tables shared by the corner segment test block.
// ----------------------------------------------------------------------------
package fcst_pkg;

  // Default parameter values.
  localparam int MaxWidthDef  = 1024;
  localparam int RunLengthDef = 12;

  // Fixed geometry of the test.
  localparam int Radius   = 3;
  localparam int Win      = 2 * Radius + 1;
  localparam int Lines    = 2 * Radius;
  localparam int RingN    = 16;
  localparam int Edge     = Radius + 1;
  localparam int MaxHeight = 4096;

  // Field widths.
  localparam int PixW     = 8;
  localparam int RowW     = 12;
  localparam int OutColW  = 10;
  localparam int DimW     = 13;
  localparam int CfgDataW = 13;
  localparam int CfgIdxW  = 2;
  localparam int FwW      = 11;
  localparam int FhW      = 13;

  // Register reset values.
  localparam logic [PixW-1:0] ThresholdRst = PixW'(20);
  localparam logic [FwW-1:0]  FrameWidthRst = FwW'(640);
  localparam logic [FhW-1:0]  FrameHeightRst = FhW'(480);

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_THRESHOLD    = 2'd0,
    CFG_FRAME_WIDTH  = 2'd1,
    CFG_FRAME_HEIGHT = 2'd2
  } cfg_index_e;

  // Ring offsets (row, column) around the center, in circular order.
  localparam int RingDy [RingN] = '{-3, -3, -2, -1, 0, 1, 2, 3, 3, 3, 2, 1, 0, -1, -2, -3};
  localparam int RingDx [RingN] = '{0, 1, 2, 3, 3, 3, 2, 1, 0, -1, -2, -3, -3, -3, -2, -1};

endpackage

@@ src/fcst_line_store.sv @@
// ----------------------------------------------------------------------------
// fcst_line_store
// Six packed line stores, one word per column, with write-to-read forwarding.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fcst_line_store
  import fcst_pkg::*;
#(
  parameter int MAX_WIDTH = MaxWidthDef,
  localparam int AddrW = $clog2(MAX_WIDTH),
  localparam int WordW = Lines * PixW
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] raddr_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WordW-1:0] wdata_i,
  output logic [WordW-1:0] rd_data_o
);

  logic [WordW-1:0] mem [MAX_WIDTH];
  logic [WordW-1:0] rd_q;
  logic [WordW-1:0] fwd_data_q;
  logic             fwd_q;

  // Memory write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; the word written in the same cycle is kept aside.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q       <= mem[raddr_i];
      fwd_data_q <= wdata_i;
    end
  end

  // A read of the column being written takes the new word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_q <= wr_en_i && (raddr_i == waddr_i);
    end
  end

  assign rd_data_o = fwd_q ? fwd_data_q : rd_q;

  `ASSERT_NEXT(a_fwd_word, clk_i, rst_ni, rd_en_i && wr_en_i && (raddr_i == waddr_i),
    rd_data_o === $past(wdata_i), "line store read missed the word written with it")

endmodule

@@ src/fcst_segment_test.sv @@
// ----------------------------------------------------------------------------
// fcst_segment_test
// Compares the sixteen ring pixels with the center and looks for a long run.
// ----------------------------------------------------------------------------
module fcst_segment_test
  import fcst_pkg::*;
#(
  parameter int RUN_LENGTH = RunLengthDef
) (
  input  logic [PixW-1:0]            center_i,
  input  logic [RingN-1:0][PixW-1:0] ring_i,
  input  logic [PixW-1:0]            threshold_i,
  output logic                       corner_o
);

  logic [RingN-1:0]   diff;
  logic [2*RingN-1:0] diff2;
  logic [RingN-1:0]   run_ok;

  // Absolute difference of each ring pixel against the threshold.
  always_comb begin
    for (int i = 0; i < RingN; i++) begin
      if (ring_i[i] > center_i) begin
        diff[i] = (ring_i[i] - center_i) >= threshold_i;
      end else begin
        diff[i] = (center_i - ring_i[i]) >= threshold_i;
      end
    end
  end

  // The ring is circular: a run may start at any of the sixteen positions.
  assign diff2 = {diff, diff};

  always_comb begin
    for (int s = 0; s < RingN; s++) begin
      run_ok[s] = &diff2[s +: RUN_LENGTH];
    end
  end

  assign corner_o = |run_ok;

endmodule

@@ src/fcst_window.sv @@
// ----------------------------------------------------------------------------
// fcst_window
// The 7x7 pixel window, shifted one column per pixel, and its corner test.
// ----------------------------------------------------------------------------
module fcst_window
  import fcst_pkg::*;
#(
  parameter int RUN_LENGTH = RunLengthDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     shift_en_i,
  input  logic [Win-1:0][PixW-1:0] col_i,
  input  logic [PixW-1:0]          threshold_i,
  output logic                     corner_o
);

  logic [PixW-1:0] win_q [Win][Win];
  logic [RingN-1:0][PixW-1:0] ring;

  // Every row moves left by one and takes its new pixel on the right.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int y = 0; y < Win; y++) begin
        for (int x = 0; x < Win; x++) begin
          win_q[y][x] <= '0;
        end
      end
    end else if (shift_en_i) begin
      for (int y = 0; y < Win; y++) begin
        for (int x = 0; x < Win - 1; x++) begin
          win_q[y][x] <= win_q[y][x+1];
        end
        win_q[y][Win-1] <= col_i[y];
      end
    end
  end

  // Gather the ring pixels in circular order.
  always_comb begin
    for (int i = 0; i < RingN; i++) begin
      ring[i] = win_q[Radius + RingDy[i]][Radius + RingDx[i]];
    end
  end

  fcst_segment_test #(
    .RUN_LENGTH(RUN_LENGTH)
  ) u_segment_test (
    .center_i   (win_q[Radius][Radius]),
    .ring_i     (ring),
    .threshold_i(threshold_i),
    .corner_o   (corner_o)
  );

endmodule

@@ src/fast_corner_segment_test_core.sv @@
// ----------------------------------------------------------------------------
// fast_corner_segment_test_core
// Corner segment test on a raster stream of 8-bit grayscale pixels.
// ----------------------------------------------------------------------------
// Pixels enter in raster order on the input channel (valid/ready), one word
// per pixel; start_of_frame_i on a word forces it to row 0, column 0.
// For every pixel at row 3 or later and column 3 or later one result word
// leaves on the output channel: the window center three rows and three
// columns back, whether it lies far enough from every edge to be checked,
// and whether it is a corner. Other pixels give no result.
// Throughput is one pixel per clock cycle unless the receiver stalls: the line
// store is one word of six bytes per column, read and written once per pixel,
// and the ring test is a single pass over the registered window.
// An accepted pixel moves through stage A, stage B (as the window shifts) and
// then the output register. When the receiver stalls, the whole pipeline holds
// and in_ready_o drops; bubbles behind a waiting result stay where they are.
// Reset clears the position counters, the window and the pipeline, and loads
// threshold 20, width 640, height 480. The line store needs no clearing.
// Configuration is written through cfg_we_i/cfg_index_i/cfg_wdata_i; the user
// must write it only while idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fast_corner_segment_test_core
  import fcst_pkg::*;
#(
  parameter int MAX_WIDTH  = MaxWidthDef,
  parameter int RUN_LENGTH = RunLengthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Pixel input.
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [PixW-1:0]     pixel_i,
  input  logic                start_of_frame_i,
  // Result output.
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [RowW-1:0]     center_row_o,
  output logic [OutColW-1:0]  center_col_o,
  output logic                checked_o,
  output logic                is_corner_o,
  // Configuration writes.
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  localparam int ColW  = $clog2(MAX_WIDTH);
  localparam int WordW = Lines * PixW;

  typedef struct packed {
    logic [RowW-1:0] cr;
    logic            chk;
    logic            emit;
  } pos_t;

  // Configuration registers.
  logic [PixW-1:0] threshold_q;
  logic [FwW-1:0]  frame_width_q;
  logic [FhW-1:0]  frame_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q    <= ThresholdRst;
      frame_width_q  <= FrameWidthRst;
      frame_height_q <= FrameHeightRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_THRESHOLD:    threshold_q    <= cfg_wdata_i[PixW-1:0];
        CFG_FRAME_WIDTH:  frame_width_q  <= cfg_wdata_i[FwW-1:0];
        CFG_FRAME_HEIGHT: frame_height_q <= cfg_wdata_i[FhW-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline flow: everything moves when the output register can take a word.
  logic pipe_en;
  logic accept;
  logic out_valid_q;

  assign pipe_en    = !out_valid_q || out_ready_i;
  assign in_ready_o = pipe_en;
  assign accept     = in_valid_i && pipe_en;

  // Frame size in use, saturated.
  logic [DimW-1:0] w_sat;
  logic [DimW-1:0] h_sat;

  always_comb begin
    if (frame_width_q == '0) begin
      w_sat = DimW'(1);
    end else if (DimW'(frame_width_q) > DimW'(MAX_WIDTH)) begin
      w_sat = DimW'(MAX_WIDTH);
    end else begin
      w_sat = DimW'(frame_width_q);
    end
    if (frame_height_q == '0) begin
      h_sat = DimW'(1);
    end else if (frame_height_q > DimW'(MaxHeight)) begin
      h_sat = DimW'(MaxHeight);
    end else begin
      h_sat = frame_height_q;
    end
  end

  // Position of the incoming pixel and of the one after it.
  logic [RowW-1:0] row_q, row_d;
  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] r0, r_cur;
  logic [ColW-1:0] c0, c_cur;
  logic [DimW-1:0] r1, r_inc, c_inc;
  logic            wrap_col;
  pos_t            pos_new;
  logic [ColW-1:0] cc_new;

  always_comb begin
    r0       = start_of_frame_i ? '0 : row_q;
    c0       = start_of_frame_i ? '0 : col_q;
    wrap_col = DimW'(c0) >= w_sat;
    c_cur    = wrap_col ? '0 : c0;
    r1       = DimW'(r0) + DimW'(wrap_col);
    r_cur    = (r1 >= h_sat) ? '0 : r1[RowW-1:0];
    c_inc    = DimW'(c_cur) + DimW'(1);
    r_inc    = DimW'(r_cur) + DimW'(1);

    if (c_inc >= w_sat) begin
      col_d = '0;
      row_d = (r_inc >= h_sat) ? '0 : r_inc[RowW-1:0];
    end else begin
      col_d = c_inc[ColW-1:0];
      row_d = r_cur;
    end

    // A center exists once three rows and three columns are behind it;
    // it is checked only with a full ring plus one pixel inside every edge.
    pos_new.emit = (r_cur >= RowW'(Radius)) && (c_cur >= ColW'(Radius));
    pos_new.chk  = (r_cur >= RowW'(Radius + Edge)) && (c_cur >= ColW'(Radius + Edge))
                   && (r_inc < h_sat) && (c_inc < w_sat);
    pos_new.cr   = r_cur - RowW'(Radius);
    cc_new       = c_cur - ColW'(Radius);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (accept) begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  // Stage A: the accepted pixel waits for its line store word.
  logic            a_valid_q;
  logic [PixW-1:0] a_pix_q;
  logic [ColW-1:0] a_c_q;
  logic [ColW-1:0] a_cc_q;
  pos_t            a_pos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (pipe_en) begin
      a_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_pix_q <= pixel_i;
      a_c_q   <= c_cur;
      a_cc_q  <= cc_new;
      a_pos_q <= pos_new;
    end
  end

  // Line store: the column word shifts up one row and takes the new pixel.
  logic             ls_wr_en;
  logic [WordW-1:0] ls_rd_data;
  logic [WordW-1:0] ls_wdata;

  assign ls_wr_en = a_valid_q && pipe_en;
  assign ls_wdata = {a_pix_q, ls_rd_data[WordW-1:PixW]};

  fcst_line_store #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_line_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (accept),
    .raddr_i  (c_cur),
    .wr_en_i  (ls_wr_en),
    .waddr_i  (a_c_q),
    .wdata_i  (ls_wdata),
    .rd_data_o(ls_rd_data)
  );

  // Window and ring test; the new column is six stored rows over the pixel.
  logic [Win-1:0][PixW-1:0] win_col;
  logic                     corner_hit;

  assign win_col = {a_pix_q, ls_rd_data};

  fcst_window #(
    .RUN_LENGTH(RUN_LENGTH)
  ) u_window (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .shift_en_i (ls_wr_en),
    .col_i      (win_col),
    .threshold_i(threshold_q),
    .corner_o   (corner_hit)
  );

  // Stage B: the center whose window is now in place.
  logic            b_valid_q;
  logic [ColW-1:0] b_cc_q;
  pos_t            b_pos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (pipe_en) begin
      b_valid_q <= a_valid_q && a_pos_q.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ls_wr_en) begin
      b_cc_q  <= a_cc_q;
      b_pos_q <= a_pos_q;
    end
  end

  // Output register.
  logic [RowW-1:0]      out_row_q;
  logic [ColW-1:0]      out_col_q;
  logic                 out_chk_q;
  logic                 out_corner_q;
  logic [ColW+OutColW-1:0] col_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pipe_en) begin
      out_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en && b_valid_q) begin
      out_row_q    <= b_pos_q.cr;
      out_col_q    <= b_cc_q;
      out_chk_q    <= b_pos_q.chk;
      out_corner_q <= b_pos_q.chk && corner_hit;
    end
  end

  assign col_ext      = {{OutColW{1'b0}}, out_col_q};
  assign out_valid_o  = out_valid_q;
  assign center_row_o = out_row_q;
  assign center_col_o = col_ext[OutColW-1:0];
  assign checked_o    = out_chk_q;
  assign is_corner_o  = out_corner_q;

  `ASSERT_ALWAYS(a_corner_checked, clk_i, rst_ni, !(out_valid_o && is_corner_o && !checked_o),
    "corner reported for an unchecked center")
  `ASSERT_ALWAYS(a_checked_row, clk_i, rst_ni,
    !(out_valid_o && checked_o) || (center_row_o >= RowW'(Edge)), "checked center too near top")
  `ASSERT_NEXT(a_stage_hold, clk_i, rst_ni, a_valid_q && !pipe_en, a_valid_q,
    "pixel lost from stage A during a stall")

endmodule
